// ===== rtl/core/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded deque package
// Shared sizes, request and status codes, and the control types of the
// cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

  // Store size, the widths that follow from it, and the word and code widths.
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int REQ_W  = 3;
  localparam int STAT_W = 2;

  // Request codes.
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_SEARCH     = 3'd4,
    REQ_TRUNC      = 3'd5
  } req_t;

  // Status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_INVALID = 2'd3
  } status_t;

  // What every cell of the chain does in a cycle.
  typedef enum logic [2:0] {
    CELL_HOLD        = 3'd0,
    CELL_SHIFT_BACK  = 3'd1,
    CELL_SHIFT_FRONT = 3'd2,
    CELL_LOAD        = 3'd3,
    CELL_SEARCH      = 3'd4
  } cell_cmd_t;

  // Control of one cell.
  typedef struct packed {
    cell_cmd_t cmd;
    logic      sel;
    logic      live;
  } cell_ctl_t;

  // Control of the whole chain from the sequencer.
  typedef struct packed {
    cell_cmd_t        cmd;
    logic [IDX_W-1:0] wr_idx;
    logic [CNT_W-1:0] count;
  } chain_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/bdq_cell.sv =====
// ----------------------------------------------------------------------------
// Deque cell
// Holds one entry, takes a word from either neighbor on a shift, loads the
// request word when selected, and registers its compare result on a search.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_cell (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire bdq_pkg::cell_ctl_t           ctl,
  input  wire signed [bdq_pkg::DATA_W-1:0]  key,
  input  wire signed [bdq_pkg::DATA_W-1:0]  from_prev,
  input  wire signed [bdq_pkg::DATA_W-1:0]  from_next,
  output logic signed [bdq_pkg::DATA_W-1:0] data_o,
  output logic                              match_o
);

  logic signed [bdq_pkg::DATA_W-1:0] data_r;
  logic signed [bdq_pkg::DATA_W-1:0] data_nxt;
  logic                              match_r;
  logic                              match_nxt;

  // Entry update: shift in from a neighbor or load the request word.
  always_comb begin
    data_nxt = data_r;
    case (ctl.cmd)
      bdq_pkg::CELL_SHIFT_BACK:  data_nxt = from_prev;
      bdq_pkg::CELL_SHIFT_FRONT: data_nxt = from_next;
      bdq_pkg::CELL_LOAD: begin
        if (ctl.sel) begin
          data_nxt = key;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  // Compare only entries inside the stored sequence.
  assign match_nxt = (ctl.cmd == bdq_pkg::CELL_SEARCH) && ctl.live && (data_r == key);

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign data_o  = data_r;
  assign match_o = match_r;

endmodule

`default_nettype wire

// ===== rtl/core/bdq_chain.sv =====
// ----------------------------------------------------------------------------
// Deque cell chain
// A row of cells with the front entry in cell zero; neighbors are wired so
// the whole sequence shifts one place either way in a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bdq_chain (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire bdq_pkg::chain_ctl_t         ctl,
  input  wire signed [bdq_pkg::DATA_W-1:0] key,
  output logic                             found_o
);

  logic signed [bdq_pkg::DATA_W-1:0] data_w  [bdq_pkg::DEPTH];
  logic [bdq_pkg::DEPTH-1:0]         match_w;

  genvar i;
  generate
    for (i = 0; i < bdq_pkg::DEPTH; i++) begin : g_cell
      bdq_pkg::cell_ctl_t                cell_ctl;
      logic signed [bdq_pkg::DATA_W-1:0] prev_w;
      logic signed [bdq_pkg::DATA_W-1:0] next_w;

      // Per-cell select and live flags from the chain control.
      assign cell_ctl.cmd  = ctl.cmd;
      assign cell_ctl.sel  = (ctl.wr_idx == bdq_pkg::IDX_W'(i));
      assign cell_ctl.live = (bdq_pkg::CNT_W'(i) < ctl.count);

      // The front cell takes the request word on a push at the front.
      if (i == 0) begin : g_first
        assign prev_w = key;
      end else begin : g_mid
        assign prev_w = data_w[i-1];
      end

      // The back cell keeps its own word on a shift toward the front.
      if (i == bdq_pkg::DEPTH - 1) begin : g_last
        assign next_w = data_w[i];
      end else begin : g_inner
        assign next_w = data_w[i+1];
      end

      bdq_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (cell_ctl),
        .key       (key),
        .from_prev (prev_w),
        .from_next (next_w),
        .data_o    (data_w[i]),
        .match_o   (match_w[i])
      );
    end
  endgenerate

  // Registered match bits of all cells are combined.
  assign found_o = |match_w;

endmodule

`default_nettype wire

// ===== rtl/core/bounded_deque_with_search.sv =====
// ----------------------------------------------------------------------------
// Bounded deque with search
// Ordered store of signed words with pushes and pops at both ends, a
// membership search and a truncate that drops front entries.
// ----------------------------------------------------------------------------
// Push, pop, refused and undefined requests load their result word into the
// output register on acceptance; a search first registers the compare in each
// cell and then loads the result; a truncate shifts the chain one place per
// dropped entry before its result is loaded. Throughput is one word per cycle
// for push and pop while the output side is not stalled. Reset clears the
// count, the sequencer and the output valid flag; the entries are not cleared.
`default_nettype none

module bounded_deque_with_search (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire [bdq_pkg::REQ_W-1:0]         in_req_type,
  input  wire signed [bdq_pkg::DATA_W-1:0] in_value,
  input  wire [4:0]                        in_new_count,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [bdq_pkg::STAT_W-1:0]       out_status,
  output logic                             out_found,
  output logic [4:0]                       out_count
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_TRUNC  = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic [bdq_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [bdq_pkg::CNT_W-1:0]  drop_r, drop_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [bdq_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic                       out_found_r, out_found_nxt;
  logic [bdq_pkg::CNT_W-1:0]  out_count_r, out_count_nxt;

  bdq_pkg::chain_ctl_t        chain_ctl;
  bdq_pkg::status_t           status_new;
  logic                       found_new;
  logic                       found_w;
  logic                       load_out;
  logic                       in_acc;
  logic                       is_full;
  logic                       is_empty;
  bdq_pkg::req_t              req;

  assign req      = bdq_pkg::req_t'(in_req_type);
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign is_full  = (count_r == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
  assign is_empty = (count_r == '0);

  // Sequencer: decodes a request and steps a truncate one shift a cycle.
  always_comb begin
    state_nxt         = state_r;
    count_nxt         = count_r;
    drop_nxt          = drop_r;
    chain_ctl.cmd     = bdq_pkg::CELL_HOLD;
    chain_ctl.wr_idx  = count_r[bdq_pkg::IDX_W-1:0];
    chain_ctl.count   = count_r;
    status_new        = bdq_pkg::STAT_OK;
    found_new         = 1'b0;
    load_out          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          load_out = 1'b1;
          case (req)
            bdq_pkg::REQ_PUSH_FRONT: begin
              if (is_full) begin
                status_new = bdq_pkg::STAT_FULL;
              end else begin
                chain_ctl.cmd = bdq_pkg::CELL_SHIFT_BACK;
                count_nxt     = count_r + bdq_pkg::CNT_W'(1);
              end
            end
            bdq_pkg::REQ_PUSH_BACK: begin
              if (is_full) begin
                status_new = bdq_pkg::STAT_FULL;
              end else begin
                chain_ctl.cmd = bdq_pkg::CELL_LOAD;
                count_nxt     = count_r + bdq_pkg::CNT_W'(1);
              end
            end
            bdq_pkg::REQ_POP_FRONT: begin
              if (is_empty) begin
                status_new = bdq_pkg::STAT_EMPTY;
              end else begin
                chain_ctl.cmd = bdq_pkg::CELL_SHIFT_FRONT;
                count_nxt     = count_r - bdq_pkg::CNT_W'(1);
              end
            end
            bdq_pkg::REQ_POP_BACK: begin
              if (is_empty) begin
                status_new = bdq_pkg::STAT_EMPTY;
              end else begin
                count_nxt = count_r - bdq_pkg::CNT_W'(1);
              end
            end
            bdq_pkg::REQ_SEARCH: begin
              chain_ctl.cmd = bdq_pkg::CELL_SEARCH;
              load_out      = 1'b0;
              state_nxt     = ST_SEARCH;
            end
            bdq_pkg::REQ_TRUNC: begin
              if (in_new_count > count_r) begin
                status_new = bdq_pkg::STAT_INVALID;
              end else if (in_new_count != count_r) begin
                load_out  = 1'b0;
                drop_nxt  = count_r - in_new_count;
                state_nxt = ST_TRUNC;
              end
            end
            default: begin
              status_new = bdq_pkg::STAT_OK;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        found_new = found_w;
        load_out  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_TRUNC: begin
        chain_ctl.cmd = bdq_pkg::CELL_SHIFT_FRONT;
        count_nxt     = count_r - bdq_pkg::CNT_W'(1);
        drop_nxt      = drop_r - bdq_pkg::CNT_W'(1);
        if (drop_r == bdq_pkg::CNT_W'(1)) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: holds a result word until it is taken.
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    if (load_out) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = status_new;
      out_found_nxt  = found_new;
      out_count_nxt  = count_nxt;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      drop_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result word registers.
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  bdq_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (chain_ctl),
    .key     (in_value),
    .found_o (found_w)
  );

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_found  = out_found_r;
  assign out_count  = out_count_r;

  // The count never exceeds the store size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
    else $error("entry count above store size");

  // A truncate in progress always has entries left to drop.
  a_trunc_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TRUNC) |-> (drop_r != '0) && (drop_r <= count_r))
    else $error("truncate step without entries to drop");

  // An accepted push with room grows the count by one.
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_full && (req == bdq_pkg::REQ_PUSH_FRONT || req == bdq_pkg::REQ_PUSH_BACK))
    |=> (count_r == $past(count_r) + bdq_pkg::CNT_W'(1)))
    else $error("push did not grow the count");

  // A search result is never lost: the output stage is free when it lands.
  a_search_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> !out_valid_r)
    else $error("search result would overwrite a pending word");

endmodule

`default_nettype wire

// ===== tb/bdq_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded deque result checker
// Watches both channels of the deque. Every request word accepted on the
// input side is applied to a mirror of the deque, and the result it must
// give is queued. Every result word accepted on the output side is compared
// field by field with the oldest queued result.
// ----------------------------------------------------------------------------

module bdq_checker
  import bdq_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  input  wire                     in_ready,
  input  wire [REQ_W-1:0]         in_req_type,
  input  wire signed [DATA_W-1:0] in_value,
  input  wire [4:0]               in_new_count,
  input  wire                     out_valid,
  input  wire                     out_ready,
  input  wire [STAT_W-1:0]        out_status,
  input  wire                     out_found,
  input  wire [4:0]               out_count,
  output int                      errors,
  output int                      pending
);

  // One result word as the deque must return it.
  typedef struct packed {
    status_t     status;
    logic        found;
    logic [4:0]  count;
  } deque_result_t;

  // Mirror of the stored sequence: circular store, front index and fill.
  logic [DATA_W-1:0] mirror_store [DEPTH];
  int                mirror_front;
  int                mirror_fill;

  // Results owed by the deque, oldest first.
  deque_result_t     results_due [$];
  int                words_seen;

  // Apply one request to the mirror and queue the result it must give.
  task automatic apply_deque_request(input logic [REQ_W-1:0]  kind,
                                     input logic [DATA_W-1:0] val,
                                     input logic [4:0]        keep);
    deque_result_t res;
    int            pos;
    res.status = STAT_OK;
    res.found  = 1'b0;
    case (kind)
      REQ_PUSH_FRONT: begin
        if (mirror_fill >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
          mirror_store[mirror_front] = val;
          mirror_fill++;
        end
      end
      REQ_PUSH_BACK: begin
        if (mirror_fill >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          mirror_store[(mirror_front + mirror_fill) % DEPTH] = val;
          mirror_fill++;
        end
      end
      REQ_POP_FRONT: begin
        if (mirror_fill == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          mirror_front = (mirror_front + 1) % DEPTH;
          mirror_fill--;
        end
      end
      REQ_POP_BACK: begin
        if (mirror_fill == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          mirror_fill--;
        end
      end
      REQ_SEARCH: begin
        // Only live entries take part, so unwritten cells are never read.
        for (pos = 0; pos < mirror_fill; pos++) begin
          if (mirror_store[(mirror_front + pos) % DEPTH] == val) begin
            res.found = 1'b1;
          end
        end
      end
      REQ_TRUNC: begin
        if (int'(keep) > mirror_fill) begin
          res.status = STAT_INVALID;
        end else begin
          mirror_front = (mirror_front + mirror_fill - int'(keep)) % DEPTH;
          mirror_fill  = int'(keep);
        end
      end
      default: begin
        // Undefined request codes leave the deque alone.
      end
    endcase
    res.count = mirror_fill[4:0];
    results_due.push_back(res);
  endtask

  // Compare one returned word with the oldest owed result.
  task automatic check_deque_result();
    deque_result_t want;
    words_seen++;
    if (results_due.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t: result word %0d with nothing owed: status %0d found %0d count %0d",
                 $realtime, words_seen, out_status, out_found, out_count);
      end
    end else begin
      want = results_due.pop_front();
      if (out_status !== want.status || out_found !== want.found ||
          out_count !== want.count) begin
        errors++;
        if (errors <= 10) begin
          $write("%0t: result word %0d: expected status %0d found %0d count %0d, ",
                 $realtime, words_seen, want.status, want.found, want.count);
          $display("got status %0d found %0d count %0d",
                   out_status, out_found, out_count);
        end
      end
    end
  endtask

  // Results leave before requests enter; a word never comes out in the
  // cycle its request went in.
  always @(posedge clk) begin
    if (!rst_n) begin
      mirror_front = 0;
      mirror_fill  = 0;
      results_due.delete();
      words_seen   = 0;
      errors       = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_deque_result();
      end
      if (in_valid && in_ready) begin
        apply_deque_request(in_req_type, in_value, in_new_count);
      end
    end
    pending = results_due.size();
  end

endmodule

// ===== tb/tb_bounded_deque_with_search.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded deque with search testbench
// Drives request words in bursts: a directed opening that hits the empty,
// full, invalid-count and undefined-code cases, then random words whose mix
// swings between filling and draining the deque. The result side stalls on
// its own pattern. A separate checker predicts and compares every word.
// ----------------------------------------------------------------------------

module tb_bounded_deque_with_search;
  import bdq_pkg::*;

  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          RANDOM_WORDS = 750;
  localparam int          SETTLE_WAIT  = 40;
  localparam logic [REQ_W-1:0] REQ_RSVD_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_7 = 3'd7;
  localparam logic [DATA_W-1:0] WORD_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_MAX  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] WORD_ONES = 32'hFFFF_FFFF;

  // Request mixes that steer the deque toward full, toward empty, or neither.
  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} req_mix_t;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              in_valid     = 1'b0;
  logic [REQ_W-1:0]  in_req_type  = '0;
  logic [DATA_W-1:0] in_value     = '0;
  logic [4:0]        in_new_count = '0;
  logic              out_ready    = 1'b0;
  wire               in_ready;
  wire               out_valid;
  wire [STAT_W-1:0]  out_status;
  wire               out_found;
  wire [4:0]         out_count;
  int                errors;
  int                pending;

  // Recently pushed values, so that searches hit and pushes repeat.
  logic [DATA_W-1:0] value_pool [8];
  int                pool_slot    = 0;
  int unsigned       cycle_count  = 0;
  int                ready_tick   = 0;
  logic [15:0]       ready_mask   = 16'hFFFF;

  always #10 clk = ~clk;

  bounded_deque_with_search dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_value     (in_value),
    .in_new_count (in_new_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_found    (out_found),
    .out_count    (out_count)
  );

  bdq_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_value     (in_value),
    .in_new_count (in_new_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_found    (out_found),
    .out_count    (out_count),
    .errors       (errors),
    .pending      (pending)
  );

  // Result side: a random stall pattern, redrawn when ready_tick comes round, sometimes none at all.
  always @(posedge clk) begin
    if (ready_tick % 64 == 0) begin
      case ($urandom_range(0, 2))
        0:       ready_mask = 16'hFFFF;
        1:       ready_mask = $urandom;
        default: ready_mask = $urandom & $urandom & $urandom;
      endcase
      ready_mask[0] = 1'b1;
    end
    out_ready <= ready_mask[ready_tick % 16];
    ready_tick++;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Present one request word and hold it until the deque takes it.
  task automatic send_word(input logic [REQ_W-1:0]  kind,
                           input logic [DATA_W-1:0] val,
                           input logic [4:0]        keep);
    in_valid     <= 1'b1;
    in_req_type  <= kind;
    in_value     <= val;
    in_new_count <= keep;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (kind == REQ_PUSH_FRONT || kind == REQ_PUSH_BACK) begin
      value_pool[pool_slot] = val;
      pool_slot = (pool_slot + 1) % 8;
    end
  endtask

  // Hold the input side off until every owed result has come back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Data word: often a recent value, sometimes an extreme, else random.
  function automatic logic [DATA_W-1:0] pick_value(input int pool_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < pool_pct) begin
      return value_pool[$urandom_range(0, 7)];
    end else if (roll < pool_pct + 8) begin
      case ($urandom_range(0, 3))
        0:       return WORD_MIN;
        1:       return WORD_MAX;
        2:       return WORD_ONES;
        default: return '0;
      endcase
    end
    return $urandom;
  endfunction

  // Build one random request word according to the current mix.
  task automatic build_word(input  req_mix_t          mix,
                            output logic [REQ_W-1:0]  kind,
                            output logic [DATA_W-1:0] val,
                            output logic [4:0]        keep);
    int push_pct;
    int pop_pct;
    int roll;
    case (mix)
      MIX_FILL:  begin push_pct = 60; pop_pct = 12; end
      MIX_DRAIN: begin push_pct = 15; pop_pct = 57; end
      default:   begin push_pct = 37; pop_pct = 35; end
    endcase
    roll = $urandom_range(0, 99);
    val  = pick_value(25);
    keep = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                       : 5'($urandom_range(0, 16));
    if (roll < push_pct) begin
      kind = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
    end else if (roll < push_pct + pop_pct) begin
      kind = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
    end else if (roll < push_pct + pop_pct + 20) begin
      kind = REQ_SEARCH;
      val  = pick_value(60);
    end else if (roll < push_pct + pop_pct + 26) begin
      kind = REQ_TRUNC;
    end else begin
      kind = $urandom_range(0, 1) ? REQ_RSVD_7 : REQ_RSVD_6;
    end
  endtask

  initial begin
    int                idx;
    int                sent;
    int                burst;
    int                gap;
    req_mix_t          mix;
    logic [REQ_W-1:0]  kind;
    logic [DATA_W-1:0] val;
    logic [4:0]        keep;
    logic [DATA_W-1:0] fill_val;

    for (idx = 0; idx < 8; idx++) begin
      value_pool[idx] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty deque: search, both pops and a truncate above the count.
    send_word(REQ_SEARCH,    '0,      5'd0);
    send_word(REQ_POP_FRONT, '0,      5'd0);
    send_word(REQ_POP_BACK,  '0,      5'd0);
    send_word(REQ_TRUNC,     '0,      5'd1);

    // Fill to the top from both ends, extremes first.
    for (idx = 0; idx < DEPTH; idx++) begin
      case (idx)
        0:       fill_val = WORD_MIN;
        1:       fill_val = WORD_MAX;
        2:       fill_val = WORD_ONES;
        3:       fill_val = '0;
        default: fill_val = $urandom;
      endcase
      send_word((idx % 2) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, fill_val, 5'd0);
    end

    // Full deque: refused pushes, a hit, undefined code, truncate cases.
    send_word(REQ_PUSH_BACK,  $urandom, 5'd0);
    send_word(REQ_PUSH_FRONT, $urandom, 5'd0);
    send_word(REQ_SEARCH,     WORD_MIN, 5'd0);
    send_word(REQ_RSVD_6,     $urandom, 5'd0);
    send_word(REQ_TRUNC,      '0,       5'd16);
    send_word(REQ_TRUNC,      '0,       5'd31);
    send_word(REQ_TRUNC,      '0,       5'd0);
    wait_results_drained();

    // Random words in bursts; the mix changes now and then.
    sent = 0;
    mix  = MIX_FILL;
    while (sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 3) == 0) begin
        mix = req_mix_t'($urandom_range(0, 2));
      end
      burst = $urandom_range(1, 12);
      for (idx = 0; idx < burst; idx++) begin
        build_word(mix, kind, val, keep);
        send_word(kind, val, keep);
        if (kind != REQ_RSVD_6 && kind != REQ_RSVD_7) begin
          sent++;
        end
      end
      if (sent % 200 < burst) begin
        wait_results_drained();
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    wait_results_drained();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bdq_pkg.sv
rtl/core/bdq_cell.sv
rtl/core/bdq_chain.sv
rtl/core/bounded_deque_with_search.sv
tb/bdq_checker.sv
tb/tb_bounded_deque_with_search.sv
